// ===== src/afns_pkg.sv =====
// ----------------------------------------------------------------------------
// afns_pkg
// Shared widths, register indexes and reset values of the aspect-fit
// nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package afns_pkg;

  // Field widths
  localparam int DIM_W      = 12;
  localparam int STRIDE_W   = 13;
  localparam int STEP_W     = 25;
  localparam int ADDR_W     = 25;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE     = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_SURFACE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]    RST_SURFACE_HEIGHT = 12'd480;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE     = 13'd640;

  // Step saturation value
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  // Divide by three: x * RECIP3 >> RECIP3_SHIFT is exact for x below 2^14
  localparam int RECIP3       = 21846;
  localparam int RECIP3_SHIFT = 16;

endpackage

// ===== src/afns_div.sv =====
// ----------------------------------------------------------------------------
// afns_div
// Restoring radix-2 divider: one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module afns_div #(
  parameter int DVD_W = 25,
  parameter int DSR_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             busy_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Hold the control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;

endmodule

// ===== src/aspect_fit_nearest_scaler.sv =====
// ----------------------------------------------------------------------------
// aspect_fit_nearest_scaler
// Address generator for a nearest-neighbor scaler with a centered 4:3 fit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per destination
//   pixel; frame_start_i restarts at the first pixel of the fitted image.
//   Output channel (out_valid_o / out_ready_i) returns one beat per input
//   beat with source and destination coordinates and addresses, row and
//   frame end marks, or frame_skipped when the geometry cannot be drawn.
//   The result is registered and appears in the cycle after its input beat;
//   one pixel per cycle is sustained while the receiver takes each result.
//   The output register lets a new beat in while the held result is taken
//   in the same cycle; when the receiver stalls with a result held,
//   in_ready_o drops until it is taken. Reset loads 640 x 480 with stride
//   640 and recomputes the fit. After reset and after every register write
//   the sequencer computes the fit, starts the per-axis step division (one
//   quotient bit per cycle, both axes in parallel) and waits for both
//   dividers, so in_ready_o stays low until the steps are captured.
//   A write also returns the position to the first pixel.
// ----------------------------------------------------------------------------
module aspect_fit_nearest_scaler #(
  parameter int SRC_WIDTH  = 320,
  parameter int SRC_HEIGHT = 200,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [afns_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [afns_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  frame_start_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [((SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1)-1:0]   source_column_o,
  output logic [((SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1)-1:0] source_row_o,
  output logic [((SRC_WIDTH * SRC_HEIGHT > 1) ?
                 $clog2(SRC_WIDTH * SRC_HEIGHT) : 1)-1:0]        source_index_o,
  output logic [afns_pkg::DIM_W-1:0]            dest_column_o,
  output logic [afns_pkg::DIM_W-1:0]            dest_row_o,
  output logic [afns_pkg::ADDR_W-1:0]           dest_address_o,
  output logic                                  row_end_o,
  output logic                                  frame_end_o,
  output logic                                  frame_skipped_o
);

  import afns_pkg::*;

  localparam int SCW = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int SRW = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int SIW = (SRC_WIDTH * SRC_HEIGHT > 1) ? $clog2(SRC_WIDTH * SRC_HEIGHT) : 1;
  localparam int XDW = $clog2(SRC_WIDTH + 1) + FRAC_BITS;
  localparam int YDW = $clog2(SRC_HEIGHT + 1) + FRAC_BITS;
  localparam int XQW = (XDW > STEP_W) ? XDW : STEP_W;
  localparam int YQW = (YDW > STEP_W) ? YDW : STEP_W;

  // Sequencer codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FIT   = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]          state_q, state_d;

  logic [DIM_W-1:0]    surf_w_q, surf_h_q;
  logic [STRIDE_W-1:0] stride_q;

  logic [DIM_W-1:0]    fit_w_q, fit_h_q, off_x_q, off_y_q;
  logic [STEP_W-1:0]   step_x_q, step_y_q;
  logic [ADDR_W-1:0]   base_addr_q;
  logic                skip_q;

  logic [STEP_W-1:0]   accum_x_q, accum_y_q;
  logic [DIM_W-1:0]    col_cnt_q, row_cnt_q;
  logic [ADDR_W-1:0]   row_addr_q;

  logic                out_valid_q;
  logic [SCW-1:0]      src_col_q;
  logic [SRW-1:0]      src_row_q;
  logic [SIW-1:0]      src_idx_q;
  logic [DIM_W-1:0]    dst_col_q, dst_row_q;
  logic [ADDR_W-1:0]   dst_addr_q;
  logic                row_end_q, frame_end_q, skipped_q;

  logic                cfg_hit;
  logic                in_fire;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_SURFACE_WIDTH ||
                                cfg_index_i == CFG_SURFACE_HEIGHT ||
                                cfg_index_i == CFG_ROW_STRIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= RST_SURFACE_WIDTH;
      surf_h_q <= RST_SURFACE_HEIGHT;
      stride_q <= RST_ROW_STRIDE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SURFACE_WIDTH:  surf_w_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_SURFACE_HEIGHT: surf_h_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_ROW_STRIDE:     stride_q <= cfg_wdata_i;
        default:            ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Letterbox fit: width-limited first, fall back to height-limited
  // ---------------------------------------------------------------------------
  logic [DIM_W+1:0]   w_times3;
  logic [DIM_W-1:0]   h_from_w;
  logic [DIM_W+1:0]   h_times4;
  logic [31:0]        w_recip;
  logic [DIM_W+1:0]   w_from_h;
  logic [DIM_W+1:0]   fit_w_raw, fit_h_raw;
  logic [DIM_W-1:0]   fit_w_d, fit_h_d;

  always_comb begin
    w_times3  = (DIM_W + 2)'(surf_w_q) * (DIM_W + 2)'(3);
    h_from_w  = w_times3[DIM_W+1:2];
    h_times4  = {surf_h_q, 2'b00};
    w_recip   = 32'(h_times4) * 32'(RECIP3);
    w_from_h  = w_recip[RECIP3_SHIFT +: DIM_W + 2];
    if (h_from_w > surf_h_q) begin
      fit_w_raw = w_from_h;
      fit_h_raw = (DIM_W + 2)'(surf_h_q);
    end else begin
      fit_w_raw = (DIM_W + 2)'(surf_w_q);
      fit_h_raw = (DIM_W + 2)'(h_from_w);
    end
    // raise to one, then limit to the surface
    if (fit_w_raw == '0) fit_w_raw = (DIM_W + 2)'(1);
    if (fit_h_raw == '0) fit_h_raw = (DIM_W + 2)'(1);
    if (fit_w_raw > (DIM_W + 2)'(surf_w_q)) fit_w_raw = (DIM_W + 2)'(surf_w_q);
    if (fit_h_raw > (DIM_W + 2)'(surf_h_q)) fit_h_raw = (DIM_W + 2)'(surf_h_q);
    if (surf_w_q == '0 || surf_h_q == '0) begin
      fit_w_d = '0;
      fit_h_d = '0;
    end else begin
      fit_w_d = fit_w_raw[DIM_W-1:0];
      fit_h_d = fit_h_raw[DIM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Step dividers, one per axis
  // ---------------------------------------------------------------------------
  logic             div_start;
  logic             div_x_busy, div_y_busy;
  logic [XDW-1:0]   quo_x;
  logic [YDW-1:0]   quo_y;
  logic [XQW-1:0]   quo_x_ext;
  logic [YQW-1:0]   quo_y_ext;
  logic [STEP_W-1:0] step_x_d, step_y_d;

  assign div_start = (state_q == ST_START);

  afns_div #(
    .DVD_W (XDW),
    .DSR_W (DIM_W)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (XDW'(SRC_WIDTH) << FRAC_BITS),
    .divisor_i  (fit_w_q),
    .quotient_o (quo_x),
    .busy_o     (div_x_busy)
  );

  afns_div #(
    .DVD_W (YDW),
    .DSR_W (DIM_W)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (YDW'(SRC_HEIGHT) << FRAC_BITS),
    .divisor_i  (fit_h_q),
    .quotient_o (quo_y),
    .busy_o     (div_y_busy)
  );

  // Saturate to the step width; an empty fit gives a zero step
  always_comb begin
    quo_x_ext = XQW'(quo_x);
    quo_y_ext = YQW'(quo_y);
    step_x_d  = (quo_x_ext > XQW'(STEP_MAX)) ? STEP_MAX : quo_x_ext[STEP_W-1:0];
    step_y_d  = (quo_y_ext > YQW'(STEP_MAX)) ? STEP_MAX : quo_y_ext[STEP_W-1:0];
    if (fit_w_q == '0) step_x_d = '0;
    if (fit_h_q == '0) step_y_d = '0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: fit, start division, wait, run
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FIT:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (!div_x_busy && !div_y_busy) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_FIT;
    endcase
    if (cfg_hit) state_d = ST_FIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture fit, skip decision, frame base address and steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_w_q     <= '0;
      fit_h_q     <= '0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      base_addr_q <= '0;
      skip_q      <= 1'b1;
    end else begin
      if (state_q == ST_FIT) begin
        fit_w_q <= fit_w_d;
        fit_h_q <= fit_h_d;
        off_x_q <= (surf_w_q - fit_w_d) >> 1;
        off_y_q <= (surf_h_q - fit_h_d) >> 1;
      end
      if (state_q == ST_START) begin
        base_addr_q <= ADDR_W'(off_y_q) * ADDR_W'(stride_q);
        skip_q      <= (fit_w_q == '0) || (fit_h_q == '0) || (stride_q == '0) ||
                       ((STRIDE_W'(off_x_q) + STRIDE_W'(fit_w_q)) > stride_q) ||
                       ((STRIDE_W'(off_y_q) + STRIDE_W'(fit_h_q)) >
                        STRIDE_W'(surf_h_q));
      end
      if (state_q == ST_DIV && !div_x_busy && !div_y_busy) begin
        step_x_q <= step_x_d;
        step_y_q <= step_y_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel walk: one destination pixel per accepted beat
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  logic [STEP_W-1:0]          ax, ay;
  logic [DIM_W-1:0]           cc, rc;
  logic [ADDR_W-1:0]          ra;
  logic [STEP_W-FRAC_BITS-1:0] ax_hi, ay_hi;
  logic [31:0]                sx_full, sy_full;
  logic [SCW-1:0]             sx;
  logic [SRW-1:0]             sy;
  logic [DIM_W-1:0]           dc, dr;
  logic                       last_col, last_row;

  always_comb begin
    // restart on frame start
    ax = frame_start_i ? '0 : accum_x_q;
    ay = frame_start_i ? '0 : accum_y_q;
    cc = frame_start_i ? '0 : col_cnt_q;
    rc = frame_start_i ? '0 : row_cnt_q;
    ra = frame_start_i ? base_addr_q : row_addr_q;

    // clamp the source position
    ax_hi   = ax[STEP_W-1:FRAC_BITS];
    ay_hi   = ay[STEP_W-1:FRAC_BITS];
    sx_full = (32'(ax_hi) >= 32'(SRC_WIDTH))  ? 32'(SRC_WIDTH - 1)  : 32'(ax_hi);
    sy_full = (32'(ay_hi) >= 32'(SRC_HEIGHT)) ? 32'(SRC_HEIGHT - 1) : 32'(ay_hi);
    sx      = SCW'(sx_full);
    sy      = SRW'(sy_full);

    dc       = off_x_q + cc;
    dr       = off_y_q + rc;
    last_col = (13'(cc) + 13'd1) >= 13'(fit_w_q);
    last_row = (13'(rc) + 13'd1) >= 13'(fit_h_q);
  end

  // Advance the position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_x_q  <= '0;
      accum_y_q  <= '0;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      row_addr_q <= '0;
    end else if (state_q == ST_FIT) begin
      accum_x_q <= '0;
      accum_y_q <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      row_addr_q <= base_addr_q;
    end else if (in_fire) begin
      if (skip_q) begin
        accum_x_q  <= '0;
        accum_y_q  <= '0;
        col_cnt_q  <= '0;
        row_cnt_q  <= '0;
        row_addr_q <= base_addr_q;
      end else if (last_col) begin
        accum_x_q <= '0;
        col_cnt_q <= '0;
        if (last_row) begin
          accum_y_q  <= '0;
          row_cnt_q  <= '0;
          row_addr_q <= base_addr_q;
        end else begin
          accum_y_q  <= ay + step_y_q;
          row_cnt_q  <= rc + DIM_W'(1);
          row_addr_q <= ra + ADDR_W'(stride_q);
        end
      end else begin
        accum_x_q  <= ax + step_x_q;
        col_cnt_q  <= cc + DIM_W'(1);
        accum_y_q  <= ay;
        row_cnt_q  <= rc;
        row_addr_q <= ra;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (skip_q) begin
        src_col_q   <= '0;
        src_row_q   <= '0;
        src_idx_q   <= '0;
        dst_col_q   <= '0;
        dst_row_q   <= '0;
        dst_addr_q  <= '0;
        row_end_q   <= 1'b0;
        frame_end_q <= 1'b0;
        skipped_q   <= 1'b1;
      end else begin
        src_col_q   <= sx;
        src_row_q   <= sy;
        src_idx_q   <= SIW'(32'(sy) * 32'(SRC_WIDTH) + 32'(sx));
        dst_col_q   <= dc;
        dst_row_q   <= dr;
        dst_addr_q  <= ra + ADDR_W'(dc);
        row_end_q   <= last_col;
        frame_end_q <= last_col && last_row;
        skipped_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign source_column_o = src_col_q;
  assign source_row_o    = src_row_q;
  assign source_index_o  = src_idx_q;
  assign dest_column_o   = dst_col_q;
  assign dest_row_o      = dst_row_q;
  assign dest_address_o  = dst_addr_q;
  assign row_end_o       = row_end_q;
  assign frame_end_o     = frame_end_q;
  assign frame_skipped_o = skipped_q;

endmodule
